// ===== hdl/rect_circle_rasterizer_core_assert.svh =====
// assertion macros for the rasterizer core
`ifndef RECT_CIRCLE_RASTERIZER_CORE_ASSERT_SVH
`define RECT_CIRCLE_RASTERIZER_CORE_ASSERT_SVH

// consequent holds in the same cycle
`define RCR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rcr assertion failed");

// consequent holds in the next cycle
`define RCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rcr assertion failed");

`endif

// ===== hdl/rcr_pkg.sv =====
package rcr_pkg;

   localparam int OPCODE_W    = 2;
   localparam int BYTE_W      = 8;
   localparam int RADIUS_W    = 7;
   localparam int COLOR_W     = 3;
   localparam int STATUS_W    = 2;
   localparam int COORD_W     = 11;
   localparam int DIST_W      = 8;
   localparam int RR_W        = 14;
   localparam int SQ_W        = 16;
   localparam int SUM_W       = 17;
   localparam int CSR_INDEX_W = 8;
   localparam int CFG_W       = 8;

   localparam logic [OPCODE_W-1:0] OP_RECT   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_CIRCLE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_READ   = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RECT_ERR = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_READ_ERR = 2'd2;

   localparam logic [COLOR_W-1:0] COLOR_BLACK = 3'd0;
   localparam logic [COLOR_W-1:0] COLOR_MAX   = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_OUTER_MARGIN = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INNER_MARGIN = 8'd1;

   localparam logic [CFG_W-1:0] OUTER_MARGIN_RESET = 8'd30;
   localparam logic [CFG_W-1:0] INNER_MARGIN_RESET = 8'd35;

   // circle scan spans 2r+5 beyond the corner, centre sits r+1 in
   localparam logic [COORD_W-1:0] CIRCLE_PAD    = 11'd5;
   localparam logic [COORD_W-1:0] CENTRE_OFFSET = 11'd1;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [BYTE_W-1:0]   pos_x;
      logic [BYTE_W-1:0]   pos_y;
      logic [BYTE_W-1:0]   rect_height;
      logic [BYTE_W-1:0]   rect_width;
      logic [RADIUS_W-1:0] radius;
      logic [COLOR_W-1:0]  color;
      logic                filled;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COLOR_W-1:0]  pixel_color;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic scan_step;
      logic take_pixel;
   } dp_cmd_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic                rect_fits;
      logic                rect_empty;
      logic                read_in_frame;
      logic                scan_last;
      logic                clear_last;
   } dp_stat_type;

endpackage

// ===== hdl/rcr_ctrl.sv =====
module rcr_ctrl import rcr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  dp_stat_type         stat,
   output dp_cmd_type          cmd,
   output logic                busy,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_DRAIN_A,
      ST_DRAIN_B,
      ST_READ,
      ST_RESP
   } state_type;

   state_type           state_ff;
   logic [STATUS_W-1:0] status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         status_ff <= STATUS_OK;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               if (stat.clear_last) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (start) begin
                  state_ff  <= ST_DECODE;
                  status_ff <= STATUS_OK;
               end
            end
            ST_DECODE: begin
               unique case (stat.opcode)
                  OP_RECT: begin
                     if (!stat.rect_fits) begin
                        status_ff <= STATUS_RECT_ERR;
                        state_ff  <= ST_RESP;
                     end else if (stat.rect_empty) begin
                        state_ff <= ST_RESP;
                     end else begin
                        state_ff <= ST_SCAN;
                     end
                  end
                  OP_CIRCLE: begin
                     state_ff <= ST_SCAN;
                  end
                  OP_READ: begin
                     if (stat.read_in_frame) begin
                        state_ff <= ST_READ;
                     end else begin
                        status_ff <= STATUS_READ_ERR;
                        state_ff  <= ST_RESP;
                     end
                  end
                  default: begin
                     state_ff <= ST_RESP;
                  end
               endcase
            end
            ST_SCAN: begin
               if (stat.scan_last) begin
                  state_ff <= ST_DRAIN_A;
               end
            end
            ST_DRAIN_A: begin
               state_ff <= ST_DRAIN_B;
            end
            ST_DRAIN_B: begin
               state_ff <= ST_RESP;
            end
            ST_READ: begin
               state_ff <= ST_RESP;
            end
            ST_RESP: begin
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign cmd.load       = start && (state_ff == ST_IDLE);
   assign cmd.clear      = (state_ff == ST_CLEAR);
   assign cmd.scan_step  = (state_ff == ST_SCAN);
   assign cmd.take_pixel = (state_ff == ST_READ);

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_valid  = (state_ff == ST_RESP);
   assign rsp_status = status_ff;

endmodule

// ===== hdl/rcr_datapath.sv =====
module rcr_datapath import rcr_pkg::*; #(
   parameter int FRAME_WIDTH  = 256,
   parameter int FRAME_HEIGHT = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  req_type                req_data,
   input  logic                   cfg_we,
   input  logic [CSR_INDEX_W-1:0] cfg_index,
   input  logic [CFG_W-1:0]       cfg_data,
   input  dp_cmd_type             cmd,
   output dp_stat_type            stat,
   output logic [COLOR_W-1:0]     pixel_color
);

   localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);

   localparam logic [COORD_W-1:0] FRAME_W_C = COORD_W'(FRAME_WIDTH);
   localparam logic [COORD_W-1:0] FRAME_H_C = COORD_W'(FRAME_HEIGHT);
   localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(DEPTH - 1);

   function automatic logic [ADDR_W-1:0] pix_addr(input logic [COORD_W-1:0] row,
                                                  input logic [COORD_W-1:0] col);
      pix_addr = ADDR_W'(int'(row) * FRAME_WIDTH + int'(col));
   endfunction

   // configuration
   logic [CFG_W-1:0] outer_ff;
   logic [CFG_W-1:0] inner_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         outer_ff <= OUTER_MARGIN_RESET;
         inner_ff <= INNER_MARGIN_RESET;
      end else if (cfg_we) begin
         if (cfg_index == CSR_OUTER_MARGIN) begin
            outer_ff <= cfg_data;
         end else if (cfg_index == CSR_INNER_MARGIN) begin
            inner_ff <= cfg_data;
         end
      end
   end

   // latched command
   logic [OPCODE_W-1:0] opcode_ff;
   logic [COORD_W-1:0]  x_ff;
   logic [COORD_W-1:0]  y_ff;
   logic [BYTE_W-1:0]   w_ff;
   logic [BYTE_W-1:0]   h_ff;
   logic [COLOR_W-1:0]  color_ff;
   logic                filled_ff;
   logic [COORD_W-1:0]  col_last_ff;
   logic [COORD_W-1:0]  row_last_ff;
   logic [COORD_W-1:0]  cx_ff;
   logic [COORD_W-1:0]  cy_ff;
   logic [RR_W-1:0]     rr_ff;
   logic [COLOR_W-1:0]  pixel_ff;
   logic [COLOR_W-1:0]  rd_data_ff;

   logic [COORD_W-1:0] x_in;
   logic [COORD_W-1:0] y_in;
   logic [COORD_W-1:0] r_in;
   logic [COORD_W-1:0] span_in;

   assign x_in    = COORD_W'(req_data.pos_x);
   assign y_in    = COORD_W'(req_data.pos_y);
   assign r_in    = COORD_W'(req_data.radius);
   assign span_in = (r_in << 1) + CIRCLE_PAD;

   // scan position
   logic [COORD_W-1:0] row_ff;
   logic [COORD_W-1:0] col_ff;
   logic               col_end;

   assign col_end = (col_ff == col_last_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         opcode_ff <= req_data.opcode;
         x_ff      <= x_in;
         y_ff      <= y_in;
         w_ff      <= req_data.rect_width;
         h_ff      <= req_data.rect_height;
         color_ff  <= (req_data.color > COLOR_MAX) ? COLOR_BLACK : req_data.color;
         filled_ff <= req_data.filled;
         cx_ff     <= x_in + r_in + CENTRE_OFFSET;
         cy_ff     <= y_in + r_in + CENTRE_OFFSET;
         rr_ff     <= RR_W'(req_data.radius) * RR_W'(req_data.radius);
         pixel_ff  <= COLOR_BLACK;
         row_ff    <= y_in;
         col_ff    <= x_in;
         if (req_data.opcode == OP_CIRCLE) begin
            col_last_ff <= x_in + span_in;
            row_last_ff <= y_in + span_in;
         end else begin
            col_last_ff <= x_in + COORD_W'(req_data.rect_width) - CENTRE_OFFSET;
            row_last_ff <= y_in + COORD_W'(req_data.rect_height) - CENTRE_OFFSET;
         end
      end else begin
         if (cmd.scan_step) begin
            if (col_end) begin
               col_ff <= x_ff;
               row_ff <= row_ff + CENTRE_OFFSET;
            end else begin
               col_ff <= col_ff + CENTRE_OFFSET;
            end
         end
         if (cmd.take_pixel) begin
            pixel_ff <= rd_data_ff;
         end
      end
   end

   // circle thresholds, registered; they stay stable during a scan as long as no margin is written
   logic [SUM_W-1:0] hi_ff;
   logic [SUM_W-1:0] lo_mag_ff;
   logic             lo_neg_ff;

   always_ff @(posedge clock) begin
      hi_ff     <= SUM_W'(rr_ff) + SUM_W'(outer_ff);
      lo_mag_ff <= SUM_W'(rr_ff) - SUM_W'(inner_ff);
      lo_neg_ff <= (rr_ff < RR_W'(inner_ff));
   end

   // stage a: offsets from the centre and border flags
   logic [COORD_W:0]   dx_full;
   logic [COORD_W:0]   dy_full;
   logic [COORD_W:0]   dx_abs;
   logic [COORD_W:0]   dy_abs;
   logic               valid_a_ff;
   logic [COORD_W-1:0] row_a_ff;
   logic [COORD_W-1:0] col_a_ff;
   logic [DIST_W-1:0]  adx_a_ff;
   logic [DIST_W-1:0]  ady_a_ff;
   logic               border_a_ff;

   assign dx_full = {1'b0, col_ff} - {1'b0, cx_ff};
   assign dy_full = {1'b0, row_ff} - {1'b0, cy_ff};
   assign dx_abs  = dx_full[COORD_W] ? -dx_full : dx_full;
   assign dy_abs  = dy_full[COORD_W] ? -dy_full : dy_full;

   always_ff @(posedge clock) begin
      row_a_ff    <= row_ff;
      col_a_ff    <= col_ff;
      adx_a_ff    <= dx_abs[DIST_W-1:0];
      ady_a_ff    <= dy_abs[DIST_W-1:0];
      border_a_ff <= (row_ff == y_ff) || (row_ff == row_last_ff) ||
                     (col_ff == x_ff) || col_end;
   end

   // stage b: squares, clipping and address
   logic               valid_b_ff;
   logic [SQ_W-1:0]    sqx_b_ff;
   logic [SQ_W-1:0]    sqy_b_ff;
   logic               border_b_ff;
   logic               in_frame_b_ff;
   logic [ADDR_W-1:0]  addr_b_ff;

   always_ff @(posedge clock) begin
      sqx_b_ff      <= SQ_W'(adx_a_ff) * SQ_W'(adx_a_ff);
      sqy_b_ff      <= SQ_W'(ady_a_ff) * SQ_W'(ady_a_ff);
      border_b_ff   <= border_a_ff;
      in_frame_b_ff <= (row_a_ff < FRAME_H_C) && (col_a_ff < FRAME_W_C);
      addr_b_ff     <= pix_addr(row_a_ff, col_a_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         valid_a_ff <= cmd.scan_step;
         valid_b_ff <= valid_a_ff;
      end
   end

   // stage c: hit test and frame write
   logic [SUM_W-1:0] dist_sq;
   logic             circle_hit;
   logic             hit;

   assign dist_sq    = SUM_W'(sqx_b_ff) + SUM_W'(sqy_b_ff);
   assign circle_hit = filled_ff ? (dist_sq < hi_ff)
                                 : ((dist_sq <= hi_ff) &&
                                    (lo_neg_ff || (dist_sq >= lo_mag_ff)));
   assign hit        = (opcode_ff == OP_CIRCLE) ? circle_hit : (filled_ff || border_b_ff);

   // frame store with clearing pass
   logic [COLOR_W-1:0] frame_mem [DEPTH];
   logic [ADDR_W-1:0]  clr_ff;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [COLOR_W-1:0] wr_data;
   logic [ADDR_W-1:0]  rd_addr;

   assign wr_en   = cmd.clear || (valid_b_ff && in_frame_b_ff && hit);
   assign wr_addr = cmd.clear ? clr_ff : addr_b_ff;
   assign wr_data = cmd.clear ? COLOR_BLACK : color_ff;
   assign rd_addr = pix_addr(y_ff, x_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= frame_mem[rd_addr];
   end

   assign stat.opcode        = opcode_ff;
   assign stat.rect_fits     = ((x_ff + COORD_W'(w_ff)) <= FRAME_W_C) &&
                               ((y_ff + COORD_W'(h_ff)) <= FRAME_H_C);
   assign stat.rect_empty    = (w_ff == '0) || (h_ff == '0);
   assign stat.read_in_frame = (x_ff < FRAME_W_C) && (y_ff < FRAME_H_C);
   assign stat.scan_last     = col_end && (row_ff == row_last_ff);
   assign stat.clear_last    = (clr_ff == LAST_ADDR);

   assign pixel_color = pixel_ff;

endmodule

// ===== hdl/rect_circle_rasterizer_core.sv =====
// draw: one frame pixel per cycle over the shape's bounding box (w*h for a rectangle, (2r+6)^2
//    for a circle); after the last pixel issue the controller passes DRAIN_A and DRAIN_B, then the result
// read: decode, READ state, then the result; rejected, empty and unused commands go from decode to the result
// next item accepted in the cycle after the result; the result strobe cannot be stalled
// reset: margins to 30/35, then a clearing pass over all FRAME_WIDTH*FRAME_HEIGHT pixels, busy high
`include "rect_circle_rasterizer_core_assert.svh"

module rect_circle_rasterizer_core import rcr_pkg::*; #(
   parameter int FRAME_WIDTH  = 256,
   parameter int FRAME_HEIGHT = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_data,
   output logic                   rsp_valid,
   output rsp_type                rsp_data
);

   dp_cmd_type          dp_cmd;
   dp_stat_type         dp_stat;
   logic [STATUS_W-1:0] rsp_status;
   logic [COLOR_W-1:0]  pixel_color;

   assign csr_ready = 1'b1;

   rcr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .stat       (dp_stat),
      .cmd        (dp_cmd),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .rsp_status (rsp_status)
   );

   rcr_datapath #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .cfg_we      (csr_valid && csr_ready),
      .cfg_index   (csr_index),
      .cfg_data    (csr_data),
      .cmd         (dp_cmd),
      .stat        (dp_stat),
      .pixel_color (pixel_color)
   );

   assign rsp_data.status      = rsp_status;
   assign rsp_data.pixel_color = pixel_color;

   `RCR_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `RCR_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)
   `RCR_ASSERT_SAME(a_strobe_busy, clock, reset, rsp_valid, busy)
   `RCR_ASSERT_SAME(a_clear_quiet, clock, reset, dp_cmd.clear, busy && !rsp_valid)

endmodule

// ===== verif/rect_circle_rasterizer_core_test.sv =====
module rect_circle_rasterizer_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import rcr_pkg::*;

   localparam int FRAME_W       = 256;
   localparam int FRAME_H       = 128;
   localparam int RANDOM_ITEMS  = 580;
   localparam int PHASES        = 6;
   localparam int QUIET_LIMIT   = 250000;
   localparam int PRINT_LIMIT   = 40;

   localparam logic [OPCODE_W-1:0]    OP_UNUSED          = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_INDEX = 8'hff;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   req_type                req_data = '0;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]       csr_data = '0;
   logic                   rsp_valid;
   rsp_type                rsp_data;

   // expected frame contents and margins
   logic [COLOR_W-1:0] frame_pixels [FRAME_W*FRAME_H];
   int                 outer_slack = int'(OUTER_MARGIN_RESET);
   int                 inner_slack = int'(INNER_MARGIN_RESET);

   req_type pending_cmds [$];
   rsp_type expected_rsps [$];

   bit idle_on = 1'b1;
   int send_gap = 0;
   int quiet_cycles = 0;
   int queued_total = 0;
   int checked_total = 0;
   int mismatch_count = 0;
   int rect_count = 0;
   int circle_count = 0;
   int read_count = 0;
   int other_count = 0;
   int csr_writes = 0;

   // bounding box of the most recent shape, used to aim reads
   int box_x = 0;
   int box_y = 0;
   int box_w = 8;
   int box_h = 8;

   rect_circle_rasterizer_core #(
      .FRAME_WIDTH (FRAME_W),
      .FRAME_HEIGHT(FRAME_H)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("%0t mismatch: %s", $realtime, what);
      end
      mismatch_count++;
   endtask

   function automatic void put_pixel(input int row, input int col,
                                     input logic [COLOR_W-1:0] ink);
      if (row >= 0 && col >= 0 && row < FRAME_H && col < FRAME_W) begin
         frame_pixels[row*FRAME_W + col] = ink;
      end
   endfunction

   // updates the expected frame and queues the expected result of one item
   task automatic rasterize_command(input req_type c);
      int x, y, h, w, r, cx, cy, hi, lo, d, row, col;
      logic [COLOR_W-1:0] ink;
      rsp_type res;
      x = int'(c.pos_x);
      y = int'(c.pos_y);
      h = int'(c.rect_height);
      w = int'(c.rect_width);
      r = int'(c.radius);
      ink = (c.color > COLOR_MAX) ? COLOR_BLACK : c.color;
      res.status = STATUS_OK;
      res.pixel_color = COLOR_BLACK;
      case (c.opcode)
         OP_RECT: begin
            rect_count++;
            if (x + w > FRAME_W || y + h > FRAME_H) begin
               res.status = STATUS_RECT_ERR;
            end else begin
               for (row = y; row < y + h; row++) begin
                  for (col = x; col < x + w; col++) begin
                     if (c.filled || row == y || row == y + h - 1 ||
                         col == x || col == x + w - 1) begin
                        put_pixel(row, col, ink);
                     end
                  end
               end
            end
         end
         OP_CIRCLE: begin
            circle_count++;
            cx = x + r + 1;
            cy = y + r + 1;
            hi = r * r + outer_slack;
            lo = r * r - inner_slack;
            for (row = y; row <= y + 2 * r + 5; row++) begin
               for (col = x; col <= x + 2 * r + 5; col++) begin
                  d = (row - cy) * (row - cy) + (col - cx) * (col - cx);
                  if (c.filled ? (d < hi) : (d <= hi && d >= lo)) begin
                     put_pixel(row, col, ink);
                  end
               end
            end
         end
         OP_READ: begin
            read_count++;
            if (x < FRAME_W && y < FRAME_H) begin
               res.pixel_color = frame_pixels[y*FRAME_W + x];
            end else begin
               res.status = STATUS_READ_ERR;
            end
         end
         default: begin
            other_count++;
         end
      endcase
      expected_rsps.push_back(res);
   endtask

   task automatic queue_cmd(input logic [OPCODE_W-1:0] op, input int x, input int y,
                            input int h, input int w, input int r, input int color,
                            input bit filled);
      req_type c;
      c.opcode = op;
      c.pos_x = BYTE_W'(x);
      c.pos_y = BYTE_W'(y);
      c.rect_height = BYTE_W'(h);
      c.rect_width = BYTE_W'(w);
      c.radius = RADIUS_W'(r);
      c.color = COLOR_W'(color);
      c.filled = filled;
      pending_cmds.push_back(c);
      queued_total++;
   endtask

   task automatic queue_random_cmd();
      req_type c;
      logic [63:0] noise;
      int pick, w, h;
      noise = {$urandom, $urandom};
      c = noise[$bits(req_type)-1:0];
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         c.opcode = OP_RECT;
         if ($urandom_range(0, 3) != 0) begin
            w = $urandom_range(0, 16);
            h = $urandom_range(0, 16);
            c.rect_width = BYTE_W'(w);
            c.rect_height = BYTE_W'(h);
            c.pos_x = BYTE_W'($urandom_range(0, FRAME_W - ((w > 0) ? w : 1)));
            c.pos_y = BYTE_W'($urandom_range(0, FRAME_H - h));
         end
         box_x = int'(c.pos_x);
         box_y = int'(c.pos_y);
         box_w = int'(c.rect_width);
         box_h = int'(c.rect_height);
      end else if (pick < 65) begin
         c.opcode = OP_CIRCLE;
         c.radius = RADIUS_W'(($urandom_range(0, 99) < 3) ? $urandom_range(0, 127)
                                                          : $urandom_range(0, 12));
         if ($urandom_range(0, 9) < 7) begin
            c.pos_y = BYTE_W'($urandom_range(0, FRAME_H - 1));
         end
         box_x = int'(c.pos_x);
         box_y = int'(c.pos_y);
         box_w = 2 * int'(c.radius) + 6;
         box_h = 2 * int'(c.radius) + 6;
      end else if (pick < 95) begin
         c.opcode = OP_READ;
         if ($urandom_range(0, 2) != 0) begin
            c.pos_x = BYTE_W'(box_x + int'($urandom_range(0, box_w)));
            c.pos_y = BYTE_W'(box_y + int'($urandom_range(0, box_h)));
         end
      end else begin
         c.opcode = OP_UNUSED;
      end
      if ($urandom_range(0, 9) != 0) begin
         c.color = COLOR_W'($urandom_range(0, 4));
      end
      pending_cmds.push_back(c);
      queued_total++;
   endtask

   task automatic wait_drained();
      while (checked_total < queued_total) begin
         @(posedge clock);
      end
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CFG_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_OUTER_MARGIN: outer_slack = int'(val);
         CSR_INNER_MARGIN: inner_slack = int'(val);
         default: ;
      endcase
      csr_writes++;
   endtask

   // command driver
   always @(posedge clock) begin : command_driver
      bit      holding;
      req_type nxt;
      if (reset) begin
         start <= 1'b0;
         send_gap <= 0;
      end else begin
         holding = start;
         nxt = req_data;
         if (start && !busy) begin
            rasterize_command(req_data);
            holding = 1'b0;
         end
         if (!holding) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
            end else if (pending_cmds.size() > 0) begin
               if (idle_on && $urandom_range(0, 5) == 0) begin
                  send_gap <= $urandom_range(1, 10);
               end else begin
                  nxt = pending_cmds.pop_front();
                  holding = 1'b1;
               end
            end
         end
         start <= holding;
         req_data <= nxt;
      end
   end

   // result monitor
   always @(posedge clock) begin : result_monitor
      rsp_type want;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("result with no command outstanding");
            end else begin
               want = expected_rsps.pop_front();
               checked_total++;
               if (rsp_data.status !== want.status) begin
                  report_mismatch($sformatf("result %0d status %0d, want %0d",
                     checked_total, rsp_data.status, want.status));
               end
               if (rsp_data.pixel_color !== want.pixel_color) begin
                  report_mismatch($sformatf("result %0d pixel_color %0d, want %0d",
                     checked_total, rsp_data.pixel_color, want.pixel_color));
               end
            end
         end
      end
   end

   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
      end
      $display("no progress for %0d cycles", QUIET_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      logic [CFG_W-1:0] outer_set [PHASES];
      logic [CFG_W-1:0] inner_set [PHASES];
      int p;
      foreach (frame_pixels[i]) begin
         frame_pixels[i] = COLOR_BLACK;
      end
      outer_set = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, OUTER_MARGIN_RESET};
      inner_set = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd0, INNER_MARGIN_RESET};
      outer_set[4] = CFG_W'($urandom_range(0, 255));
      inner_set[4] = CFG_W'($urandom_range(0, 255));
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // corners, frame-sized shapes, fit errors, empty and clipped shapes, out-of-frame reads, an unused opcode
      queue_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0);
      queue_cmd(OP_READ, 255, 127, 0, 0, 0, 0, 0);
      queue_cmd(OP_READ, 0, 128, 0, 0, 0, 0, 0);
      queue_cmd(OP_READ, 255, 255, 255, 255, 127, 7, 1);
      queue_cmd(OP_RECT, 1, 1, 127, 255, 0, 1, 1);
      queue_cmd(OP_READ, 255, 127, 0, 0, 0, 0, 0);
      queue_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0);
      queue_cmd(OP_RECT, 0, 0, 128, 255, 0, 3, 0);
      queue_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0);
      queue_cmd(OP_READ, 128, 64, 0, 0, 0, 0, 0);
      queue_cmd(OP_RECT, 2, 0, 1, 255, 0, 2, 1);
      queue_cmd(OP_RECT, 0, 1, 128, 1, 0, 2, 1);
      queue_cmd(OP_RECT, 255, 255, 255, 255, 127, 7, 1);
      queue_cmd(OP_RECT, 10, 10, 5, 0, 0, 4, 1);
      queue_cmd(OP_RECT, 10, 10, 0, 5, 0, 4, 0);
      queue_cmd(OP_RECT, 10, 10, 4, 4, 0, 7, 1);
      queue_cmd(OP_READ, 11, 11, 0, 0, 0, 0, 0);
      queue_cmd(OP_RECT, 40, 40, 1, 1, 0, 5, 0);
      queue_cmd(OP_READ, 40, 40, 0, 0, 0, 0, 0);
      queue_cmd(OP_CIRCLE, 20, 20, 0, 0, 0, 2, 1);
      queue_cmd(OP_READ, 21, 21, 0, 0, 0, 0, 0);
      queue_cmd(OP_CIRCLE, 200, 100, 0, 0, 127, 4, 0);
      queue_cmd(OP_CIRCLE, 250, 120, 0, 0, 5, 6, 1);
      queue_cmd(OP_UNUSED, 255, 255, 255, 255, 127, 4, 1);
      queue_cmd(OP_READ, 255, 127, 0, 0, 0, 0, 0);

      for (p = 0; p < PHASES; p++) begin
         wait_drained();
         write_csr(CSR_OUTER_MARGIN, outer_set[p]);
         write_csr(CSR_INNER_MARGIN, inner_set[p]);
         if (p == 2) begin
            write_csr(CSR_UNMAPPED_INDEX, CFG_W'($urandom_range(0, 255)));
         end
         idle_on = (p < PHASES - 2);
         repeat (RANDOM_ITEMS / PHASES) queue_random_cmd();
      end

      wait_drained();
      repeat (16) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", expected_rsps.size()));
      end
      $display("covered %0d rectangles, %0d circles, %0d reads, %0d unused opcodes",
               rect_count, circle_count, read_count, other_count);
      $display("%0d results checked over %0d margin writes, %0d mismatches",
               checked_total, csr_writes, mismatch_count);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
